/* sv/smac_pkg.sv */
// shared types and constants for the int8 simd mac alu
// holds mode codes, the decoded operation type and the queue item layout
// no dependencies
package smac_pkg;

	// mode codes as they arrive on the input channel
	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_MAC = 3'd3;
	localparam logic [2:0] MODE_CLR = 3'd4;

	// datapath sizes
	localparam int WORD_W   = 32;
	localparam int LANES    = 4;
	localparam int LANE_W   = 8;
	localparam int OFFSET_W = 9;
	localparam int BIAS_W   = OFFSET_W + 1;
	localparam int PROD_W   = LANE_W + BIAS_W;
	localparam int SUM_W    = PROD_W + 2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(QUEUE_DEPTH);

	// decoded operation
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_MAC,
		OP_CLR,
		OP_NOP
	} op_t;

	// one classified item
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} item_t;

	// front to queue
	typedef struct packed {
		logic  push;
		item_t item;
	} q_wr_t;

	// queue to back
	typedef struct packed {
		logic  avail;
		item_t item;
	} q_rd_t;

endpackage

/* sv/simd_int8_mac_alu_top.sv */
// Four-lane int8 multiply-accumulate alu with add, subtract and multiply. One item is taken
// per cycle when nothing stalls, and each gives one result, registered in a queue entry, stage 1 and stage 2;
// the sustained rate of one item a cycle is held by the accumulator add in the second
// execution stage, which closes on itself every cycle. A two-entry queue sits between the
// decoding front and the execution back, so an input stall only appears when the queue fills.
// The input offset register is written through cfg_write/cfg_data and should change only
// while the block is idle.
// top level; depends on smac_pkg, smac_front, smac_queue, smac_back
module simd_int8_mac_alu_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [smac_pkg::OFFSET_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    mode,
	input  logic [smac_pkg::WORD_W-1:0]   first_operand,
	input  logic [smac_pkg::WORD_W-1:0]   second_operand,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smac_pkg::WORD_W-1:0]   result
);

	smac_pkg::q_wr_t wr;
	smac_pkg::q_rd_t rd;
	logic            full;
	logic            pop;

	// decode and push
	smac_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.full           (full),
		.wr             (wr)
	);

	// decoupling queue
	smac_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.pop    (pop),
		.rd     (rd)
	);

	// execution
	smac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.pop       (pop),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

endmodule

/* sv/smac_front.sv */
// front part: input handshake and mode decode
// pushes classified items into the queue; depends on smac_pkg
module smac_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 mode,
	input  logic [smac_pkg::WORD_W-1:0] first_operand,
	input  logic [smac_pkg::WORD_W-1:0] second_operand,
	input  logic                       full,
	output smac_pkg::q_wr_t            wr
);

	smac_pkg::op_t op;

	// classify the mode, anything unknown becomes a no-op
	always_comb begin
		unique case (mode)
			smac_pkg::MODE_ADD: op = smac_pkg::OP_ADD;
			smac_pkg::MODE_SUB: op = smac_pkg::OP_SUB;
			smac_pkg::MODE_MUL: op = smac_pkg::OP_MUL;
			smac_pkg::MODE_MAC: op = smac_pkg::OP_MAC;
			smac_pkg::MODE_CLR: op = smac_pkg::OP_CLR;
			default:            op = smac_pkg::OP_NOP;
		endcase
	end

	// take an item whenever the queue has room
	assign in_stall       = full;
	assign wr.push        = in_valid && !full;
	assign wr.item.op     = op;
	assign wr.item.first  = first_operand;
	assign wr.item.second = second_operand;

endmodule

/* sv/smac_queue.sv */
// short item queue between front and back
// two entries, full flag decoded from a registered fill count; depends on smac_pkg
module smac_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  smac_pkg::q_wr_t wr,
	output logic            full,
	input  logic            pop,
	output smac_pkg::q_rd_t rd
);

	smac_pkg::item_t                  mem_q [smac_pkg::QUEUE_DEPTH];
	logic [smac_pkg::PTR_W-1:0]       wr_ptr_q;
	logic [smac_pkg::PTR_W-1:0]       rd_ptr_q;
	logic [smac_pkg::CNT_W-1:0]       count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full     = (count_q == smac_pkg::QUEUE_FULL);
	assign rd.avail = (count_q != '0);
	assign rd.item  = mem_q[rd_ptr_q];

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smac_pkg::QUEUE_FULL)
		else $error("queue count beyond depth");

	// front only pushes into a queue with room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full)
		else $error("push into full queue");

	// pop only from a non-empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd.avail)
		else $error("pop from empty queue");

endmodule

/* sv/smac_back.sv */
// back part: execution pipeline, accumulator and output register
// stage 1 holds lane products and scalar results, stage 2 the result; depends on smac_pkg
module smac_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smac_pkg::q_rd_t               rd,
	output logic                          pop,
	input  logic                          cfg_write,
	input  logic [smac_pkg::OFFSET_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smac_pkg::WORD_W-1:0]   result
);

	logic signed [smac_pkg::OFFSET_W-1:0] offset_q;
	logic [smac_pkg::WORD_W-1:0]          acc_q;

	logic                                 vld_s1;
	smac_pkg::op_t                        op_s1;
	logic [smac_pkg::WORD_W-1:0]          res_s1;
	logic signed [smac_pkg::PROD_W-1:0]   prod_s1 [smac_pkg::LANES];

	logic                                 vld_s2;
	logic [smac_pkg::WORD_W-1:0]          result_s2;

	logic                                 s1_load;
	logic                                 s2_load;
	logic [smac_pkg::WORD_W-1:0]          res_d;
	logic signed [smac_pkg::PROD_W-1:0]   prod_d [smac_pkg::LANES];
	logic signed [smac_pkg::SUM_W-1:0]    lane_sum;
	logic [smac_pkg::WORD_W-1:0]          acc_next;

	// pipeline advance
	assign s2_load = !vld_s2 || !out_stall;
	assign s1_load = !vld_s1 || s2_load;
	assign pop     = rd.avail && s1_load;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_write) begin
			offset_q <= cfg_data;
		end
	end

	// lane products: signed filter byte times offset input byte
	always_comb begin
		for (int l = 0; l < smac_pkg::LANES; l++) begin
			logic signed [smac_pkg::LANE_W-1:0] fbyte;
			logic signed [smac_pkg::LANE_W-1:0] ibyte;
			logic signed [smac_pkg::BIAS_W-1:0] biased;
			fbyte     = rd.item.first[l*smac_pkg::LANE_W +: smac_pkg::LANE_W];
			ibyte     = rd.item.second[l*smac_pkg::LANE_W +: smac_pkg::LANE_W];
			biased    = smac_pkg::BIAS_W'(ibyte) + smac_pkg::BIAS_W'(offset_q);
			prod_d[l] = smac_pkg::PROD_W'(fbyte) * smac_pkg::PROD_W'(biased);
		end
	end

	// scalar operations
	always_comb begin
		unique case (rd.item.op)
			smac_pkg::OP_ADD: res_d = rd.item.first + rd.item.second;
			smac_pkg::OP_SUB: res_d = rd.item.first - rd.item.second;
			smac_pkg::OP_MUL: res_d = rd.item.first * rd.item.second;
			default:          res_d = '0;
		endcase
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_load) begin
			vld_s1 <= rd.avail;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1   <= rd.item.op;
			res_s1  <= res_d;
			prod_s1 <= prod_d;
		end
	end

	// reduce the lane products and add to the accumulator
	always_comb begin
		lane_sum = '0;
		for (int l = 0; l < smac_pkg::LANES; l++) begin
			lane_sum = lane_sum + smac_pkg::SUM_W'(prod_s1[l]);
		end
		acc_next = acc_q + smac_pkg::WORD_W'(lane_sum);
	end

	// stage 2 control and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else if (s2_load) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				unique case (op_s1)
					smac_pkg::OP_MAC: acc_q <= acc_next;
					smac_pkg::OP_CLR: acc_q <= '0;
					default:          acc_q <= acc_q;
				endcase
			end
		end
	end

	// stage 2 result
	always_ff @(posedge clk) begin
		if (s2_load && vld_s1) begin
			unique case (op_s1)
				smac_pkg::OP_MAC: result_s2 <= acc_next;
				smac_pkg::OP_CLR: result_s2 <= '0;
				default:          result_s2 <= res_s1;
			endcase
		end
	end

	assign out_valid = vld_s2;
	assign result    = result_s2;

	// a held result freezes the accumulator
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && out_stall) |=> $stable(acc_q))
		else $error("accumulator moved while output held");

	// clear zeroes accumulator and result together
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && s2_load && op_s1 == smac_pkg::OP_CLR) |=> (acc_q == '0 && result_s2 == '0))
		else $error("clear did not zero accumulator");

	// a blocked stage 1 item is not dropped
	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s2_load) |=> vld_s1)
		else $error("stage 1 item lost");

endmodule
